### src/fbc_pkg.sv
// Shared types and constants for the frustum box cull block.
`timescale 1ns / 1ps

package fbc_pkg;

   // Plane register layout: three Q1.14 normal components, then the offset d.
   localparam int PLANE_W        = 64;
   localparam int NORM_W         = 16;
   localparam int FRAC_BITS      = 14;
   localparam int NUM_PLANE_REGS = 6;

   // Configuration index and cached plane field widths.
   localparam int CSR_IDX_W = 3;
   localparam int CACHE_W   = 3;

   // Verdict codes.
   localparam logic [1:0] V_INSIDE    = 2'd0;
   localparam logic [1:0] V_INTERSECT = 2'd1;
   localparam logic [1:0] V_OUTSIDE   = 2'd2;

   // Running classification handed from one plane cell to the next.
   typedef struct packed {
      logic               found;      // some plane so far has the box fully outside
      logic [CACHE_W-1:0] first_idx;  // lowest such plane
      logic               isect;      // some plane so far cuts the box
      logic               hit;        // the cached plane has the box fully outside
   } cull_stat_type;

endpackage

### src/frustum_box_cull.sv
// Top level of the frustum box cull block: a chain of plane cells and the final verdict.
`timescale 1ns / 1ps

// Classifies one axis-aligned box per clock cycle against PLANE_COUNT frustum planes.
// Each box word passes down a chain of plane cells, one cell per plane, and each cell
// spends two register stages on it (corner products, then sum and compare). The chain
// moves as a whole: while a result word waits on rsp_tready, every cell holds and
// req_tready is low. Planes are written through the csr port (index 0 to 5, 64 bits
// each: normal x, y, z in Q1.14 from bit 0 up, offset d in bits 63:48); writes are
// taken at any time but are meant to happen only while no box is in flight.
module frustum_box_cull import fbc_pkg::*; #(
   parameter int PLANE_COUNT = 6,
   parameter int COORD_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // From bit 0: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   // (COORD_BITS each), cached_plane (3), zero padding.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [((6*COORD_BITS+CACHE_W+7)/8)*8-1:0] req_tdata,
   // From bit 0: verdict (2), cache_write (1), new_cached_plane (3), zero padding.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [PLANE_W-1:0]         csr_data
);

   logic                       enable;
   logic                       chain_valid [PLANE_COUNT+1];
   logic [2:0][COORD_BITS-1:0] chain_lo    [PLANE_COUNT+1];
   logic [2:0][COORD_BITS-1:0] chain_hi    [PLANE_COUNT+1];
   logic [CACHE_W-1:0]         chain_cache [PLANE_COUNT+1];
   cull_stat_type              chain_stat  [PLANE_COUNT+1];

   // The chain advances whenever the result slot is empty or being taken.
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;
   assign csr_ready  = 1'b1;

   // Unpack the request word into the head of the chain.
   always_comb begin
      chain_valid[0] = req_tvalid;
      for (int k = 0; k < 3; k++) begin
         chain_lo[0][k] = req_tdata[k*COORD_BITS +: COORD_BITS];
         chain_hi[0][k] = req_tdata[(3+k)*COORD_BITS +: COORD_BITS];
      end
      chain_cache[0] = req_tdata[6*COORD_BITS +: CACHE_W];
      chain_stat[0]  = '0;
   end

   // One cell per plane.
   generate
      for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
         fbc_cell #(
            .COORD_BITS (COORD_BITS),
            .CELL_INDEX (i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .enable    (enable),
            .csr_write (csr_valid),
            .csr_index (csr_index),
            .csr_data  (csr_data),
            .in_valid  (chain_valid[i]),
            .in_lo     (chain_lo[i]),
            .in_hi     (chain_hi[i]),
            .in_cache  (chain_cache[i]),
            .in_stat   (chain_stat[i]),
            .out_valid (chain_valid[i+1]),
            .out_lo    (chain_lo[i+1]),
            .out_hi    (chain_hi[i+1]),
            .out_cache (chain_cache[i+1]),
            .out_stat  (chain_stat[i+1])
         );
      end
   endgenerate

   cull_stat_type      last_stat;
   logic [1:0]         verdict;
   logic               cache_write;
   logic [CACHE_W-1:0] new_cached_plane;

   // Final verdict: a cache hit wins, then the lowest rejecting plane, then any cut.
   always_comb begin
      last_stat        = chain_stat[PLANE_COUNT];
      verdict          = V_INSIDE;
      cache_write      = 1'b0;
      new_cached_plane = '0;
      if (last_stat.hit) begin
         verdict = V_OUTSIDE;
      end else if (last_stat.found) begin
         verdict          = V_OUTSIDE;
         cache_write      = 1'b1;
         new_cached_plane = last_stat.first_idx;
      end else if (last_stat.isect) begin
         verdict = V_INTERSECT;
      end
   end

   assign rsp_tvalid = chain_valid[PLANE_COUNT];
   assign rsp_tdata  = {2'b00, new_cached_plane, cache_write, verdict};

endmodule

### src/fbc_cell.sv
// One plane cell: holds one frustum plane and tests the passing box against it.
`timescale 1ns / 1ps

module fbc_cell import fbc_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int CELL_INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         csr_write,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [PLANE_W-1:0]           csr_data,
   input  logic                         in_valid,
   input  logic [2:0][COORD_BITS-1:0]   in_lo,
   input  logic [2:0][COORD_BITS-1:0]   in_hi,
   input  logic [CACHE_W-1:0]           in_cache,
   input  cull_stat_type                in_stat,
   output logic                         out_valid,
   output logic [2:0][COORD_BITS-1:0]   out_lo,
   output logic [2:0][COORD_BITS-1:0]   out_hi,
   output logic [CACHE_W-1:0]           out_cache,
   output cull_stat_type                out_stat
);

   localparam int PROD_W = COORD_BITS + NORM_W;
   localparam int SUM_W  = (PROD_W + 2 > NORM_W + FRAC_BITS + 1) ?
                           PROD_W + 2 : NORM_W + FRAC_BITS + 1;
   localparam logic [CACHE_W-1:0] CELL_ID = CACHE_W'(CELL_INDEX);

   logic [PLANE_W-1:0] plane;

   // Plane register; cells past the register file see an all-zero plane.
   generate
      if (CELL_INDEX < NUM_PLANE_REGS) begin : g_reg
         logic [PLANE_W-1:0] plane_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               plane_ff <= '0;
            end else if (csr_write && csr_index == CSR_IDX_W'(CELL_INDEX)) begin
               plane_ff <= csr_data;
            end
         end
         assign plane = plane_ff;
      end else begin : g_zero
         assign plane = '0;
      end
   endgenerate

   logic signed [NORM_W-1:0]     norm [3];
   logic signed [NORM_W-1:0]     offset;
   logic signed [COORD_BITS-1:0] near_pt [3];
   logic signed [COORD_BITS-1:0] far_pt [3];
   logic signed [PROD_W-1:0]     pn_in [3];
   logic signed [PROD_W-1:0]     pf_in [3];

   // Pick the near and far corners by normal sign, then form the products.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         norm[k]    = $signed(plane[k*NORM_W +: NORM_W]);
         near_pt[k] = norm[k][NORM_W-1] ? $signed(in_hi[k]) : $signed(in_lo[k]);
         far_pt[k]  = norm[k][NORM_W-1] ? $signed(in_lo[k]) : $signed(in_hi[k]);
         pn_in[k]   = PROD_W'(norm[k]) * PROD_W'(near_pt[k]);
         pf_in[k]   = PROD_W'(norm[k]) * PROD_W'(far_pt[k]);
      end
      offset = $signed(plane[3*NORM_W +: NORM_W]);
   end

   logic                       valid_a_ff;
   logic [2:0][COORD_BITS-1:0] lo_a_ff;
   logic [2:0][COORD_BITS-1:0] hi_a_ff;
   logic [CACHE_W-1:0]         cache_a_ff;
   cull_stat_type              stat_a_ff;
   logic signed [PROD_W-1:0]   pn_ff [3];
   logic signed [PROD_W-1:0]   pf_ff [3];

   // First stage: products registered with the box and running status.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
      end
      if (enable) begin
         lo_a_ff    <= in_lo;
         hi_a_ff    <= in_hi;
         cache_a_ff <= in_cache;
         stat_a_ff  <= in_stat;
         for (int k = 0; k < 3; k++) begin
            pn_ff[k] <= pn_in[k];
            pf_ff[k] <= pf_in[k];
         end
      end
   end

   logic signed [SUM_W-1:0] sum_near;
   logic signed [SUM_W-1:0] sum_far;
   logic signed [SUM_W-1:0] bound;
   logic                    near_out;
   logic                    far_out;
   cull_stat_type           stat_in;

   // Second stage: dot products against d scaled to Q.14, then fold into status.
   always_comb begin
      sum_near = SUM_W'(pn_ff[0]) + SUM_W'(pn_ff[1]) + SUM_W'(pn_ff[2]);
      sum_far  = SUM_W'(pf_ff[0]) + SUM_W'(pf_ff[1]) + SUM_W'(pf_ff[2]);
      bound    = SUM_W'(offset) <<< FRAC_BITS;
      near_out = sum_near > bound;
      far_out  = sum_far > bound;
      stat_in  = stat_a_ff;
      if (near_out && far_out) begin
         if (!stat_a_ff.found) begin
            stat_in.found     = 1'b1;
            stat_in.first_idx = CELL_ID;
         end
         if (cache_a_ff == CELL_ID) begin
            stat_in.hit = 1'b1;
         end
      end
      if (near_out != far_out) begin
         stat_in.isect = 1'b1;
      end
   end

   logic                       valid_b_ff;
   logic [2:0][COORD_BITS-1:0] lo_b_ff;
   logic [2:0][COORD_BITS-1:0] hi_b_ff;
   logic [CACHE_W-1:0]         cache_b_ff;
   cull_stat_type              stat_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_b_ff <= valid_a_ff;
      end
      if (enable) begin
         lo_b_ff    <= lo_a_ff;
         hi_b_ff    <= hi_a_ff;
         cache_b_ff <= cache_a_ff;
         stat_b_ff  <= stat_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_lo    = lo_b_ff;
   assign out_hi    = hi_b_ff;
   assign out_cache = cache_b_ff;
   assign out_stat  = stat_b_ff;

endmodule

### test/tb_top.sv
// Self-checking testbench for the frustum box cull block.
`timescale 1ns / 1ps

module tb_top;
   import fbc_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 6;
   localparam int PLANES         = 6;
   localparam int COORD_W        = 16;
   localparam int REQ_W          = ((6*COORD_W+CACHE_W+7)/8)*8;
   localparam int LATENCY        = 2*PLANES;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int COORD_MIN      = -32768;
   localparam int COORD_MAX      = 32767;
   localparam int UNIT_NORMAL    = 1 << FRAC_BITS;
   localparam int PHASE_BOXES    = 205;

   // Cached plane values that mean there is no cache entry.
   localparam logic [CACHE_W-1:0] NO_CACHE     = 3'd6;
   localparam logic [CACHE_W-1:0] CACHE_UNUSED = 3'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      PLANE_0, PLANE_1, PLANE_2, PLANE_3, PLANE_4, PLANE_5, SPARE_6, SPARE_7
   } csr_reg_type;

   // Box word as it travels on req_tdata, first field in the lowest bits.
   typedef struct packed {
      logic [REQ_W-6*COORD_W-CACHE_W-1:0] pad;
      logic [CACHE_W-1:0]                 cached;
      logic [COORD_W-1:0]                 max_z;
      logic [COORD_W-1:0]                 max_y;
      logic [COORD_W-1:0]                 max_x;
      logic [COORD_W-1:0]                 min_z;
      logic [COORD_W-1:0]                 min_y;
      logic [COORD_W-1:0]                 min_x;
   } box_word_type;

   // Result word as it travels on rsp_tdata.
   typedef struct packed {
      logic [1:0]         pad;
      logic [CACHE_W-1:0] new_plane;
      logic               cache_write;
      logic [1:0]         verdict;
   } cull_word_type;

   typedef logic [PLANE_W-1:0] plane_set_type [NUM_PLANE_REGS];

   // Keeps a copy of the plane registers and the verdicts owed by the block.
   class verdict_board;
      logic [PLANE_W-1:0] planes [PLANES] = '{default: '0};
      cull_word_type      pending_verdicts [$];
      int                 errors = 0;

      function void set_plane(logic [CSR_IDX_W-1:0] idx, logic [PLANE_W-1:0] value);
         if (idx < NUM_PLANE_REGS) planes[idx] = value;
      endfunction

      // Side of one plane the box lies on, from its nearest and farthest corners.
      function logic [1:0] plane_side(int p, box_word_type b);
         logic [PLANE_W-1:0] r;
         longint lo [3];
         longint hi [3];
         longint n, d, dot_near, dot_far;
         bit near_out, far_out;
         int k;
         r = planes[p];
         lo[0] = longint'($signed(b.min_x));
         lo[1] = longint'($signed(b.min_y));
         lo[2] = longint'($signed(b.min_z));
         hi[0] = longint'($signed(b.max_x));
         hi[1] = longint'($signed(b.max_y));
         hi[2] = longint'($signed(b.max_z));
         d = longint'($signed(r[PLANE_W-1 -: NORM_W]));
         dot_near = 0;
         dot_far = 0;
         for (k = 0; k < 3; k++) begin
            n = longint'($signed(r[NORM_W*k +: NORM_W]));
            if (n >= 0) begin
               dot_near += n * lo[k];
               dot_far  += n * hi[k];
            end else begin
               dot_near += n * hi[k];
               dot_far  += n * lo[k];
            end
         end
         near_out = dot_near > d * UNIT_NORMAL;
         far_out  = dot_far > d * UNIT_NORMAL;
         if (near_out != far_out) return V_INTERSECT;
         return near_out ? V_OUTSIDE : V_INSIDE;
      endfunction

      // The cached plane gets the first look; otherwise the lowest rejecting plane wins.
      function cull_word_type predict_verdict(box_word_type b);
         cull_word_type res;
         logic [1:0] side;
         int p;
         res = '0;
         res.verdict = V_INSIDE;
         if (b.cached != NO_CACHE && b.cached < PLANES &&
             plane_side(b.cached, b) == V_OUTSIDE) begin
            res.verdict = V_OUTSIDE;
            return res;
         end
         for (p = 0; p < PLANES; p++) begin
            side = plane_side(p, b);
            if (side == V_OUTSIDE) begin
               res.verdict = V_OUTSIDE;
               res.cache_write = 1'b1;
               res.new_plane = p[CACHE_W-1:0];
               return res;
            end
            if (side == V_INTERSECT) res.verdict = V_INTERSECT;
         end
         return res;
      endfunction

      function void note_box(box_word_type b);
         pending_verdicts.push_back(predict_verdict(b));
      endfunction

      function void check_verdict(cull_word_type got);
         cull_word_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result word with no box waiting: expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.verdict !== want.verdict) begin
            $display("%0t: verdict mismatch: expected %0d, actual %0d",
                     $time, want.verdict, got.verdict);
            errors++;
         end
         if (got.cache_write !== want.cache_write) begin
            $display("%0t: cache_write mismatch: expected %0d, actual %0d",
                     $time, want.cache_write, got.cache_write);
            errors++;
         end
         if (got.new_plane !== want.new_plane) begin
            $display("%0t: new_cached_plane mismatch: expected %0d, actual %0d",
                     $time, want.new_plane, got.new_plane);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PLANE_W-1:0]   csr_data = '0;

   verdict_board sb = new;
   int           boxes_sent = 0;
   bit           send_idle = 1'b0;
   int           quiet_cycles = 0;

   frustum_box_cull #(
      .PLANE_COUNT(PLANES),
      .COORD_BITS (COORD_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // Record every accepted box and check every accepted result word.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_box(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_verdict(rsp_tdata);
   end

   // End the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("frustum_box_cull verification failed");
         $finish;
      end
   end

   // Result side: random stalls, switched off for stretches of words.
   initial begin
      int stall;
      int taken;
      bit recv_idle;
      taken = 0;
      recv_idle = 1'b1;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (taken % 40 == 0) recv_idle = ($urandom_range(0, 2) != 0);
         stall = recv_idle ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
         @(negedge clock);
      end
   end

   function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
      return {d[15:0], nz[15:0], ny[15:0], nx[15:0]};
   endfunction

   function automatic box_word_type mk_box(int lx, int ly, int lz, int hx, int hy, int hz,
                                           int cache);
      box_word_type b;
      b = '0;
      b.min_x = lx[COORD_W-1:0];
      b.min_y = ly[COORD_W-1:0];
      b.min_z = lz[COORD_W-1:0];
      b.max_x = hx[COORD_W-1:0];
      b.max_y = hy[COORD_W-1:0];
      b.max_z = hz[COORD_W-1:0];
      b.cached = cache[CACHE_W-1:0];
      return b;
   endfunction

   // Six axis planes bounding the cube |x|, |y|, |z| <= half.
   function automatic plane_set_type axis_planes(int half);
      plane_set_type vals;
      int n [3];
      int a;
      for (a = 0; a < 3; a++) begin
         n = '{0, 0, 0};
         n[a] = UNIT_NORMAL;
         vals[2*a] = pack_plane(n[0], n[1], n[2], half);
         n[a] = -UNIT_NORMAL;
         vals[2*a+1] = pack_plane(n[0], n[1], n[2], half);
      end
      return vals;
   endfunction

   // Offer one box word after a random gap and hold it until it is taken.
   task automatic send_box(box_word_type b);
      int gap;
      if (boxes_sent % 40 == 0) send_idle = ($urandom_range(0, 2) != 0);
      gap = send_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      boxes_sent++;
      @(negedge clock);
   endtask

   // Stop offering boxes until every owed verdict has come back.
   task automatic drain_verdicts();
      req_tvalid <= 1'b0;
      while (sb.pending_verdicts.size() != 0) @(negedge clock);
   endtask

   // Write all six plane registers back to back, optionally also the unused indexes.
   task automatic load_planes(plane_set_type vals, bit add_spare);
      int i, total;
      csr_reg_type idx;
      logic [PLANE_W-1:0] data;
      total = add_spare ? NUM_PLANE_REGS + 2 : NUM_PLANE_REGS;
      for (i = 0; i < total; i++) begin
         idx = csr_reg_type'(i);
         data = (i < NUM_PLANE_REGS) ? vals[i] : {$urandom, $urandom};
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= data;
         do @(posedge clock); while (!csr_ready);
         sb.set_plane(idx, data);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Random boxes: mostly well-formed boxes around the planes, some raw noise.
   task automatic run_random(int count, int span, int max_ext);
      box_word_type b;
      int lo [3];
      int hi [3];
      int hits [$];
      int i, a, c, h, pick, p;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 10) begin
            b = REQ_W'({$urandom, $urandom, $urandom, $urandom});
            b.pad = '0;
         end else begin
            for (a = 0; a < 3; a++) begin
               c = int'($urandom_range(0, 2*span)) - span;
               h = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, COORD_MAX))
                                                : int'($urandom_range(0, max_ext));
               lo[a] = (c - h < COORD_MIN) ? COORD_MIN : c - h;
               hi[a] = (c + h > COORD_MAX) ? COORD_MAX : c + h;
            end
            b = mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], NO_CACHE);
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               // Aim the cache at one of the planes that rejects the box, if any.
               hits.delete();
               for (p = 0; p < PLANES; p++)
                  if (sb.plane_side(p, b) == V_OUTSIDE) hits.push_back(p);
               if (hits.size() != 0)
                  b.cached = CACHE_W'(hits[$urandom_range(0, hits.size() - 1)]);
            end else if (pick < 7) begin
               b.cached = CACHE_W'($urandom_range(0, 7));
            end
         end
         send_box(b);
      end
   endtask

   initial begin
      plane_set_type vals;
      int i;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Planes still all zero after reset: nothing is ever rejected.
      send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                      PLANE_0));
      send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                      NO_CACHE));
      drain_verdicts();

      // Axis cube of half size 10000, then the directed cases.
      load_planes(axis_planes(10000), 1'b0);
      send_box(mk_box(-100, -100, -100, 100, 100, 100, NO_CACHE));
      send_box(mk_box(9000, 0, 0, 11000, 10, 10, NO_CACHE));
      send_box(mk_box(20000, 0, 0, 30000, 10, 10, NO_CACHE));
      send_box(mk_box(0, 0, -30000, 10, 10, -20000, NO_CACHE));
      // Cache hit: the cached plane rejects, so no cache update.
      send_box(mk_box(0, 0, -30000, 10, 10, -20000, PLANE_5));
      // Cached plane does not reject, a later plane does.
      send_box(mk_box(0, -30000, 0, 10, -20000, 10, PLANE_1));
      // Two planes reject: the cached one wins, else the lowest one.
      send_box(mk_box(20000, 20000, 0, 30000, 30000, 10, PLANE_2));
      send_box(mk_box(20000, 20000, 0, 30000, 30000, 10, NO_CACHE));
      send_box(mk_box(20000, 0, 0, 30000, 10, 10, CACHE_UNUSED));
      send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                      PLANE_0));
      send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                      PLANE_4));
      send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                      NO_CACHE));
      // Min above max on one axis is used as given.
      send_box(mk_box(20000, 0, 0, -20000, 10, 10, PLANE_0));
      run_random(PHASE_BOXES, 20000, 3000);
      drain_verdicts();

      // Fully random plane registers.
      for (i = 0; i < NUM_PLANE_REGS; i++) vals[i] = {$urandom, $urandom};
      load_planes(vals, 1'b0);
      run_random(PHASE_BOXES, COORD_MAX, 8000);
      drain_verdicts();

      // Frustum-like planes with each normal component between minus one and plus one.
      for (i = 0; i < NUM_PLANE_REGS; i++)
         vals[i] = pack_plane(int'($urandom_range(0, 2*UNIT_NORMAL)) - UNIT_NORMAL,
                              int'($urandom_range(0, 2*UNIT_NORMAL)) - UNIT_NORMAL,
                              int'($urandom_range(0, 2*UNIT_NORMAL)) - UNIT_NORMAL,
                              int'($urandom_range(0, 16000)) - 8000);
      load_planes(vals, 1'b0);
      run_random(PHASE_BOXES, 20000, 2000);
      drain_verdicts();

      // Extreme normals and offsets; the unused register indexes are written too.
      vals[PLANE_0] = pack_plane(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX);
      vals[PLANE_1] = pack_plane(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN);
      for (i = 2; i < NUM_PLANE_REGS; i++)
         vals[i] = pack_plane($urandom_range(0, 2) == 0 ? COORD_MIN : COORD_MAX,
                              $urandom_range(0, 2) == 0 ? 0 : COORD_MIN,
                              $urandom_range(0, 2) == 0 ? COORD_MAX : 0,
                              $urandom_range(0, 1) == 0 ? COORD_MIN : COORD_MAX);
      load_planes(vals, 1'b1);
      run_random(PHASE_BOXES, COORD_MAX, 4000);
      drain_verdicts();

      // Small cube with one plane left all zero.
      vals = axis_planes(100);
      vals[PLANE_3] = '0;
      load_planes(vals, 1'b0);
      run_random(PHASE_BOXES, 2000, 300);
      drain_verdicts();

      repeat (LATENCY + 4) @(posedge clock);
      if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
         $display("frustum_box_cull verification clean");
      end else begin
         $display("frustum_box_cull verification failed");
      end
      $finish;
   end

endmodule
